### sv/tpris_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpris_pkg
// Types, codes and helpers shared by the trusted proxy real IP selector.
// ----------------------------------------------------------------------------
package tpris_pkg;

  localparam int unsigned AddrW = 128;

  localparam logic [1:0] CmdLoad = 2'd0;
  localparam logic [1:0] CmdPeer = 2'd1;
  localparam logic [1:0] CmdFwd  = 2'd2;

  localparam logic [1:0] StatLoadOk  = 2'd0;
  localparam logic [1:0] StatLoadRej = 2'd1;
  localparam logic [1:0] StatFwd     = 2'd2;
  localparam logic [1:0] StatPeer    = 2'd3;

  localparam logic [7:0] MaxV4Prefix = 8'd32;
  localparam logic [7:0] MaxV6Prefix = 8'd128;

  localparam int unsigned QDepth = 2;

  typedef enum logic [2:0] {
    KindLoadWr,
    KindLoadClr,
    KindLoadRej,
    KindPeer,
    KindFwd
  } kind_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic        is_v6;
    logic        unspecified;
    logic        header_present;
    logic        last_entry;
    logic [3:0]  entry_index;
    logic [7:0]  prefix_length;
    logic        entry_enable;
  } tpris_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] real_addr_high;
    logic [63:0] real_addr_low;
    logic        real_is_v6;
  } tpris_out_t;

  // Classified item handed from the front to the back
  typedef struct packed {
    kind_e       kind;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic        is_v6;
    logic        unspecified;
    logic        header_present;
    logic        last_entry;
    logic [3:0]  entry_index;
    logic [7:0]  prefix_length;
  } tpris_item_t;

  typedef struct packed {
    logic [63:0] net_high;
    logic [63:0] net_low;
    logic        v6;
    logic [7:0]  prefix;
  } tpris_entry_t;

  // Left-align an address: IPv4 moves to the top 32 bits
  function automatic logic [AddrW-1:0] align_addr(logic v6, logic [63:0] hi, logic [63:0] lo);
    logic [AddrW-1:0] r;
    if (v6) begin
      r = {hi, lo};
    end else begin
      r = {lo[31:0], 96'd0};
    end
    return r;
  endfunction

  function automatic tpris_out_t make_out(logic [1:0] st, logic v6, logic [63:0] hi,
                                          logic [63:0] lo);
    tpris_out_t o;
    o.status         = st;
    o.real_addr_high = v6 ? hi : 64'd0;
    o.real_addr_low  = v6 ? lo : {32'd0, lo[31:0]};
    o.real_is_v6     = v6;
    return o;
  endfunction

endpackage

### sv/trusted_proxy_real_ip_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trusted_proxy_real_ip_select
// Picks the real client address from a peer and its forwarded hop list.
// ----------------------------------------------------------------------------
// Load transfers write or clear one slot of the trusted CIDR table, or are
// rejected with a status. A peer transfer with a header, and a forwarded
// transfer in multi-hop mode that names an address while a request is open,
// are checked against the table one entry per cycle through the single table
// read port and prefix comparator; a scan stops early on a match. Other
// transfers finish without a scan. A two-entry queue lets new transfers
// land while a scan runs or a result waits in the result register; the back
// end takes the next item only once that register is empty or being drained.
// The mode register is written through the config port.
module trusted_proxy_real_ip_select #(
  parameter int unsigned TRUST_ENTRIES = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  tpris_pkg::tpris_in_t  in_data_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  output tpris_pkg::tpris_out_t out_data_o,
  input  logic                  out_stall_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_data_i,
  output logic                  cfg_ready_o
);
  import tpris_pkg::*;

  logic        q_push, q_pop, q_full, q_empty;
  tpris_item_t q_in, q_out;

  assign cfg_ready_o = 1'b1;

  tpris_front #(
    .TRUST_ENTRIES(TRUST_ENTRIES)
  ) u_front (
    .in_valid_i(in_valid_i),
    .in_data_i (in_data_i),
    .in_stall_o(in_stall_o),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_item_o  (q_in)
  );

  tpris_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (q_in),
    .full_o (q_full),
    .pop_i  (q_pop),
    .item_o (q_out),
    .empty_o(q_empty)
  );

  tpris_back #(
    .TRUST_ENTRIES(TRUST_ENTRIES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_item_i   (q_out),
    .q_pop_o    (q_pop),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .out_stall_i(out_stall_i)
  );

endmodule

### sv/tpris_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpris_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module tpris_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/tpris_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpris_front
// Accepts input items, checks load requests and normalizes addresses.
// ----------------------------------------------------------------------------
module tpris_front #(
  parameter int unsigned TRUST_ENTRIES = 16
) (
  input  logic                 in_valid_i,
  input  tpris_pkg::tpris_in_t in_data_i,
  output logic                 in_stall_o,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output tpris_pkg::tpris_item_t q_item_o
);
  import tpris_pkg::*;

  logic       idx_bad;
  logic       plen_bad;
  logic       known;
  tpris_item_t it;

  assign idx_bad  = int'(in_data_i.entry_index) >= int'(TRUST_ENTRIES);
  assign plen_bad = in_data_i.is_v6 ? (in_data_i.prefix_length > MaxV6Prefix)
                                    : (in_data_i.prefix_length > MaxV4Prefix);

  always_comb begin
    known             = 1'b1;
    it.kind           = KindFwd;
    it.addr_high      = in_data_i.is_v6 ? in_data_i.addr_high : 64'd0;
    it.addr_low       = in_data_i.is_v6 ? in_data_i.addr_low
                                        : {32'd0, in_data_i.addr_low[31:0]};
    it.is_v6          = in_data_i.is_v6;
    it.unspecified    = in_data_i.unspecified;
    it.header_present = in_data_i.header_present;
    it.last_entry     = in_data_i.last_entry;
    it.entry_index    = in_data_i.entry_index;
    it.prefix_length  = in_data_i.prefix_length;
    case (in_data_i.cmd)
      CmdLoad: begin
        if (idx_bad) begin
          it.kind = KindLoadRej;
        end else if (!in_data_i.entry_enable) begin
          it.kind = KindLoadClr;
        end else if (plen_bad) begin
          it.kind = KindLoadRej;
        end else begin
          it.kind = KindLoadWr;
        end
      end
      CmdPeer: it.kind = KindPeer;
      CmdFwd:  it.kind = KindFwd;
      default: known = 1'b0;
    endcase
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i && known;
  assign q_item_o   = it;

endmodule

### sv/tpris_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpris_fifo
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module tpris_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  tpris_pkg::tpris_item_t item_i,
  output logic                   full_o,
  input  logic                   pop_i,
  output tpris_pkg::tpris_item_t item_o,
  output logic                   empty_o
);
  import tpris_pkg::*;

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW = $clog2(QDepth + 1);

  tpris_item_t     mem_q [QDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == CntW'(QDepth);
  assign empty_o = cnt_q == '0;
  assign item_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(QDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(QDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

### sv/tpris_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpris_back
// Executes queued items: trust table updates, trust scans, request tracking.
// ----------------------------------------------------------------------------
module tpris_back #(
  parameter int unsigned TRUST_ENTRIES = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_empty_i,
  input  tpris_pkg::tpris_item_t q_item_i,
  output logic                   q_pop_o,
  input  logic                   cfg_we_i,
  input  logic                   cfg_data_i,
  output logic                   out_valid_o,
  output tpris_pkg::tpris_out_t  out_data_o,
  input  logic                   out_stall_i
);
  import tpris_pkg::*;

  localparam int unsigned IdxW = (TRUST_ENTRIES > 1) ? $clog2(TRUST_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(TRUST_ENTRIES + 1);
  localparam logic StIdle = 1'b0;
  localparam logic StScan = 1'b1;
  localparam logic [AddrW-1:0] Ones = '1;

  logic                     state_q, state_d;
  tpris_item_t              cur_q, cur_d;
  logic [63:0]              peer_high_q, peer_high_d, peer_low_q, peer_low_d;
  logic                     peer_v6_q, peer_v6_d;
  logic                     searching_q, searching_d;
  logic                     mode_q;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic                     pend_q, pend_d;
  logic                     vld_rd_q, vld_rd_d;
  logic [TRUST_ENTRIES-1:0] valid_q, valid_d;
  logic                     out_valid_q, out_valid_d;
  tpris_out_t               out_q, out_d;

  logic                     pop;
  logic                     ram_we, ram_re;
  logic [IdxW-1:0]          widx, ridx;
  tpris_entry_t             wentry, rentry;
  logic [$bits(tpris_entry_t)-1:0] rdata;
  logic [AddrW-1:0]         cur_al, ent_al, pmask;
  logic                     hit, scan_end;

  assign widx   = IdxW'(q_item_i.entry_index);
  assign ridx   = cnt_q[IdxW-1:0];
  assign wentry = '{net_high: q_item_i.addr_high, net_low: q_item_i.addr_low,
                    v6: q_item_i.is_v6, prefix: q_item_i.prefix_length};
  assign rentry = tpris_entry_t'(rdata);

  tpris_ram #(
    .WIDTH($bits(tpris_entry_t)),
    .DEPTH(TRUST_ENTRIES),
    .AW   (IdxW)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(widx),
    .wdata_i(wentry),
    .re_i   (ram_re),
    .raddr_i(ridx),
    .rdata_o(rdata)
  );

  // Shared prefix comparator
  assign cur_al   = align_addr(cur_q.is_v6, cur_q.addr_high, cur_q.addr_low);
  assign ent_al   = align_addr(rentry.v6, rentry.net_high, rentry.net_low);
  assign pmask    = ~(Ones >> rentry.prefix);
  assign hit      = pend_q && vld_rd_q && (rentry.v6 == cur_q.is_v6) &&
                    (((cur_al ^ ent_al) & pmask) == '0);
  assign scan_end = cnt_q == CntW'(TRUST_ENTRIES);

  assign pop = (state_q == StIdle) && !q_empty_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    peer_high_d = peer_high_q;
    peer_low_d  = peer_low_q;
    peer_v6_d   = peer_v6_q;
    searching_d = searching_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    vld_rd_d    = vld_rd_q;
    valid_d     = valid_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (pop) begin
          cur_d  = q_item_i;
          cnt_d  = '0;
          pend_d = 1'b0;
          case (q_item_i.kind)
            KindLoadRej: begin
              out_valid_d = 1'b1;
              out_d       = make_out(StatLoadRej, 1'b0, 64'd0, 64'd0);
            end
            KindLoadClr: begin
              valid_d[widx] = 1'b0;
              out_valid_d   = 1'b1;
              out_d         = make_out(StatLoadOk, 1'b0, 64'd0, 64'd0);
            end
            KindLoadWr: begin
              ram_we        = 1'b1;
              valid_d[widx] = 1'b1;
              out_valid_d   = 1'b1;
              out_d         = make_out(StatLoadOk, 1'b0, 64'd0, 64'd0);
            end
            KindPeer: begin
              peer_high_d = q_item_i.addr_high;
              peer_low_d  = q_item_i.addr_low;
              peer_v6_d   = q_item_i.is_v6;
              if (!q_item_i.header_present) begin
                searching_d = 1'b0;
                out_valid_d = 1'b1;
                out_d       = make_out(StatPeer, q_item_i.is_v6, q_item_i.addr_high,
                                       q_item_i.addr_low);
              end else begin
                state_d = StScan;
              end
            end
            KindFwd: begin
              if (searching_q) begin
                if (!mode_q) begin
                  searching_d = 1'b0;
                  out_valid_d = 1'b1;
                  if (q_item_i.unspecified) begin
                    out_d = make_out(StatPeer, peer_v6_q, peer_high_q, peer_low_q);
                  end else begin
                    out_d = make_out(StatFwd, q_item_i.is_v6, q_item_i.addr_high,
                                     q_item_i.addr_low);
                  end
                end else if (q_item_i.unspecified) begin
                  if (q_item_i.last_entry) begin
                    searching_d = 1'b0;
                    out_valid_d = 1'b1;
                    out_d       = make_out(StatPeer, peer_v6_q, peer_high_q, peer_low_q);
                  end
                end else begin
                  state_d = StScan;
                end
              end
            end
            default: ;
          endcase
        end
      end
      StScan: begin
        if (!scan_end) begin
          ram_re   = 1'b1;
          cnt_d    = cnt_q + 1'b1;
          vld_rd_d = valid_q[ridx];
        end
        pend_d = !scan_end;
        if (hit || scan_end) begin
          state_d = StIdle;
          if (cur_q.kind == KindPeer) begin
            searching_d = hit;
            if (!hit) begin
              out_valid_d = 1'b1;
              out_d       = make_out(StatPeer, peer_v6_q, peer_high_q, peer_low_q);
            end
          end else if (hit) begin
            if (cur_q.last_entry) begin
              searching_d = 1'b0;
              out_valid_d = 1'b1;
              out_d       = make_out(StatPeer, peer_v6_q, peer_high_q, peer_low_q);
            end
          end else begin
            searching_d = 1'b0;
            out_valid_d = 1'b1;
            out_d       = make_out(StatFwd, cur_q.is_v6, cur_q.addr_high, cur_q.addr_low);
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      peer_high_q <= '0;
      peer_low_q  <= '0;
      peer_v6_q   <= 1'b0;
      searching_q <= 1'b0;
      mode_q      <= 1'b1;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      vld_rd_q    <= 1'b0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      peer_high_q <= peer_high_d;
      peer_low_q  <= peer_low_d;
      peer_v6_q   <= peer_v6_d;
      searching_q <= searching_d;
      if (cfg_we_i) begin
        mode_q <= cfg_data_i;
      end
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      vld_rd_q    <= vld_rd_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    out_q <= out_d;
  end

  assign q_pop_o     = pop;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### verif/tb_trusted_proxy_real_ip_select.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_trusted_proxy_real_ip_select
// Self-checking bench for the trusted proxy real IP selector.
// ----------------------------------------------------------------------------
// A queue of pending transfers, filled up front, feeds a clocked driver. A
// clocked monitor predicts each accepted transfer against a local copy of the
// trust table, peer and hop mode, and checks every result transfer in order.
// A directed run of table loads, peer and hop walks comes first, then
// randomized requests in phases that alternate the hop mode. Both sides wait
// a random gap between transfers, with calm stretches of no waiting.
// ----------------------------------------------------------------------------
module tb_trusted_proxy_real_ip_select;
  import tpris_pkg::*;

  localparam int          TrustSlots   = 16;
  localparam int          PoolSize     = 8;
  localparam int          SettleCycles = 100;
  localparam int          TailCycles   = 100;
  localparam int          QuietLimit   = 2000;
  localparam int          PhaseItems   = 200;
  localparam logic [1:0]  CmdSpare     = 2'd3;

  typedef enum logic {OpItem, OpMode} stim_op_e;

  typedef struct {
    stim_op_e  op;
    tpris_in_t data;
    logic      mode;
  } stim_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  tpris_in_t  in_data_i   = '0;
  logic       in_stall_o;
  logic       out_valid_o;
  tpris_out_t out_data_o;
  logic       out_stall_i = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_data_i  = 1'b0;
  logic       cfg_ready_o;

  trusted_proxy_real_ip_select #(
    .TRUST_ENTRIES(TrustSlots)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predicted state
  logic [127:0] trust_net [TrustSlots];
  logic         trust_v6  [TrustSlots];
  logic [7:0]   trust_len [TrustSlots];
  logic         trust_on  [TrustSlots];
  logic [63:0]  peer_hi;
  logic [63:0]  peer_lo;
  logic         peer_v6;
  logic         open_req;
  logic         hop_mode;

  tpris_out_t   expected_picks[$];
  stim_t        pending[$];

  int in_issued    = 0;
  int in_accepted  = 0;
  int cfg_issued   = 0;
  int cfg_accepted = 0;
  int out_accepted = 0;
  int out_seen     = 0;
  int in_gap       = 0;
  int out_hold     = 0;
  int settle       = 0;
  int quiet        = 0;
  int fails        = 0;
  int stim_count   = 0;
  bit in_calm      = 1'b0;
  bit out_calm     = 1'b0;

  // Stimulus pool of CIDR blocks, left-aligned
  logic [127:0] pool_net [PoolSize];
  logic         pool_v6  [PoolSize];
  logic [7:0]   pool_len [PoolSize];

  function automatic logic [127:0] left_aligned(logic v6, logic [63:0] hi, logic [63:0] lo);
    return v6 ? {hi, lo} : {lo[31:0], 96'd0};
  endfunction

  function automatic logic [127:0] prefix_mask(logic [7:0] len);
    logic [127:0] m;
    if (len == 8'd0) begin
      m = '0;
    end else begin
      m = ~128'd0 << (128 - int'(len));
    end
    return m;
  endfunction

  function automatic logic hop_trusted(logic v6, logic [63:0] hi, logic [63:0] lo);
    logic [127:0] a;
    logic         hit;
    a   = left_aligned(v6, hi, lo);
    hit = 1'b0;
    for (int i = 0; i < TrustSlots; i++) begin
      if (trust_on[i] && trust_v6[i] == v6 &&
          ((a ^ trust_net[i]) & prefix_mask(trust_len[i])) == '0) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  function automatic tpris_out_t pick_result(logic [1:0] st, logic v6, logic [63:0] hi,
                                             logic [63:0] lo);
    tpris_out_t r;
    r.status         = st;
    r.real_addr_high = v6 ? hi : 64'd0;
    r.real_addr_low  = v6 ? lo : {32'd0, lo[31:0]};
    r.real_is_v6     = v6;
    return r;
  endfunction

  task automatic predict_pick(input tpris_in_t it);
    logic [7:0] max_len;
    max_len = it.is_v6 ? MaxV6Prefix : MaxV4Prefix;
    case (it.cmd)
      CmdLoad: begin
        if (!it.entry_enable) begin
          trust_on[it.entry_index] = 1'b0;
          expected_picks.push_back(pick_result(StatLoadOk, 1'b0, 64'd0, 64'd0));
        end else if (it.prefix_length > max_len) begin
          expected_picks.push_back(pick_result(StatLoadRej, 1'b0, 64'd0, 64'd0));
        end else begin
          trust_net[it.entry_index] = left_aligned(it.is_v6, it.addr_high, it.addr_low);
          trust_v6[it.entry_index]  = it.is_v6;
          trust_len[it.entry_index] = it.prefix_length;
          trust_on[it.entry_index]  = 1'b1;
          expected_picks.push_back(pick_result(StatLoadOk, 1'b0, 64'd0, 64'd0));
        end
      end
      CmdPeer: begin
        peer_v6 = it.is_v6;
        peer_hi = it.is_v6 ? it.addr_high : 64'd0;
        peer_lo = it.is_v6 ? it.addr_low : {32'd0, it.addr_low[31:0]};
        if (!it.header_present || !hop_trusted(it.is_v6, it.addr_high, it.addr_low)) begin
          open_req = 1'b0;
          expected_picks.push_back(pick_result(StatPeer, peer_v6, peer_hi, peer_lo));
        end else begin
          open_req = 1'b1;
        end
      end
      CmdFwd: begin
        if (open_req) begin
          if (!hop_mode) begin
            open_req = 1'b0;
            if (it.unspecified) begin
              expected_picks.push_back(pick_result(StatPeer, peer_v6, peer_hi, peer_lo));
            end else begin
              expected_picks.push_back(pick_result(StatFwd, it.is_v6, it.addr_high,
                                                   it.addr_low));
            end
          end else if (it.unspecified || hop_trusted(it.is_v6, it.addr_high, it.addr_low)) begin
            if (it.last_entry) begin
              open_req = 1'b0;
              expected_picks.push_back(pick_result(StatPeer, peer_v6, peer_hi, peer_lo));
            end
          end else begin
            open_req = 1'b0;
            expected_picks.push_back(pick_result(StatFwd, it.is_v6, it.addr_high,
                                                 it.addr_low));
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_pick(input tpris_out_t got);
    tpris_out_t want;
    if (expected_picks.size() == 0) begin
      $display("%0t: unexpected result, expected none, got status %0d addr %h_%h v6 %0d",
               $time, got.status, got.real_addr_high, got.real_addr_low, got.real_is_v6);
      fails++;
    end else begin
      want = expected_picks.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
        fails++;
      end
      if (got.real_addr_high !== want.real_addr_high) begin
        $display("%0t: real_addr_high expected %h, got %h", $time, want.real_addr_high,
                 got.real_addr_high);
        fails++;
      end
      if (got.real_addr_low !== want.real_addr_low) begin
        $display("%0t: real_addr_low expected %h, got %h", $time, want.real_addr_low,
                 got.real_addr_low);
        fails++;
      end
      if (got.real_is_v6 !== want.real_is_v6) begin
        $display("%0t: real_is_v6 expected %0d, got %0d", $time, want.real_is_v6,
                 got.real_is_v6);
        fails++;
      end
    end
  endtask

  // Monitor: checks results, predicts accepted inputs, tracks mode writes
  always @(posedge clk_i) begin : monitor
    logic moved;
    moved = 1'b0;
    if (!rst_ni) begin
      for (int i = 0; i < TrustSlots; i++) begin
        trust_on[i] = 1'b0;
      end
      peer_hi  = '0;
      peer_lo  = '0;
      peer_v6  = 1'b0;
      open_req = 1'b0;
      hop_mode = 1'b1;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        check_pick(out_data_o);
        out_accepted++;
        moved = 1'b1;
      end
      if (in_valid_i && !in_stall_o) begin
        predict_pick(in_data_i);
        in_accepted++;
        moved = 1'b1;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        hop_mode = cfg_data_i;
        cfg_accepted++;
        moved = 1'b1;
      end
      quiet = moved ? 0 : quiet + 1;
      if (quiet >= QuietLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, QuietLimit);
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic int pick_wait(bit calm);
    return calm ? 0 : int'($urandom_range(0, 17));
  endfunction

  // Driver: input items and mode writes from the pending queue
  always @(negedge clk_i) begin : driver
    logic      nv;
    logic      ncv;
    logic      ncd;
    tpris_in_t nd;
    nv  = in_valid_i;
    nd  = in_data_i;
    ncv = cfg_valid_i;
    ncd = cfg_data_i;
    if (rst_ni) begin
      if (in_valid_i && in_accepted == in_issued) nv = 1'b0;
      if (cfg_valid_i && cfg_accepted == cfg_issued) ncv = 1'b0;
      if (!nv && !ncv) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending.size() > 0) begin
          if (pending[0].op == OpItem) begin
            nd = pending[0].data;
            void'(pending.pop_front());
            nv = 1'b1;
            in_issued++;
            in_gap = pick_wait(in_calm);
            if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
          end else if (expected_picks.size() == 0 && in_accepted == in_issued) begin
            if (settle >= SettleCycles) begin
              ncv = 1'b1;
              ncd = pending[0].mode;
              void'(pending.pop_front());
              cfg_issued++;
              settle = 0;
            end else begin
              settle++;
            end
          end else begin
            settle = 0;
          end
        end
      end
    end
    in_valid_i  <= nv;
    in_data_i   <= nd;
    cfg_valid_i <= ncv;
    cfg_data_i  <= ncd;
  end

  // Result side back-pressure
  always @(negedge clk_i) begin : result_stall
    if (out_accepted != out_seen) begin
      out_seen = out_accepted;
      out_hold = pick_wait(out_calm);
      if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
    end
    if (out_hold > 0) begin
      out_stall_i <= 1'b1;
      if (out_valid_o) out_hold--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic tpris_in_t noise_item();
    tpris_in_t    it;
    logic [191:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it  = raw[$bits(tpris_in_t)-1:0];
    it.addr_high = rand64();
    it.addr_low  = rand64();
    return it;
  endfunction

  // {hi, lo} for a left-aligned address; IPv4 gets junk in the unused bits
  function automatic logic [127:0] split_addr(logic v6, logic [127:0] a);
    return v6 ? a : {rand64(), $urandom, a[127:96]};
  endfunction

  function automatic logic [127:0] v4(logic [31:0] a);
    return {rand64(), $urandom, a};
  endfunction

  function automatic tpris_in_t make_load(logic [3:0] slot, logic v6, logic [127:0] hl,
                                          logic [7:0] len, logic en);
    tpris_in_t it;
    it               = noise_item();
    it.cmd           = CmdLoad;
    it.is_v6         = v6;
    it.addr_high     = hl[127:64];
    it.addr_low      = hl[63:0];
    it.entry_index   = slot;
    it.prefix_length = len;
    it.entry_enable  = en;
    return it;
  endfunction

  function automatic tpris_in_t make_peer(logic v6, logic [127:0] hl, logic hdr);
    tpris_in_t it;
    it                = noise_item();
    it.cmd            = CmdPeer;
    it.is_v6          = v6;
    it.addr_high      = hl[127:64];
    it.addr_low       = hl[63:0];
    it.header_present = hdr;
    return it;
  endfunction

  function automatic tpris_in_t make_hop(logic v6, logic [127:0] hl, logic unspec,
                                         logic last);
    tpris_in_t it;
    it             = noise_item();
    it.cmd         = CmdFwd;
    it.is_v6       = v6;
    it.addr_high   = hl[127:64];
    it.addr_low    = hl[63:0];
    it.unspecified = unspec;
    it.last_entry  = last;
    return it;
  endfunction

  task automatic push_item(input tpris_in_t it);
    pending.push_back('{op: OpItem, data: it, mode: 1'b0});
  endtask

  task automatic push_mode(input logic m);
    pending.push_back('{op: OpMode, data: '0, mode: m});
  endtask

  task automatic seed_pool();
    int r;
    int max_len;
    for (int k = 0; k < PoolSize; k++) begin
      pool_v6[k]  = 1'($urandom_range(0, 1));
      pool_net[k] = {rand64(), rand64()};
      max_len     = pool_v6[k] ? 128 : 32;
      r           = $urandom_range(0, 9);
      if (r == 0) pool_len[k] = 8'd0;
      else if (r == 1) pool_len[k] = 8'(max_len);
      else pool_len[k] = 8'($urandom_range(1, max_len));
    end
  endtask

  task automatic pick_addr(output logic v6, output logic [127:0] hl);
    int           k;
    logic [127:0] m;
    if ($urandom_range(0, 99) < 55) begin
      k  = $urandom_range(0, PoolSize - 1);
      m  = prefix_mask(pool_len[k]);
      v6 = pool_v6[k];
      hl = split_addr(v6, (pool_net[k] & m) | ({rand64(), rand64()} & ~m));
    end else begin
      v6 = 1'($urandom_range(0, 1));
      hl = split_addr(v6, {rand64(), rand64()});
    end
  endtask

  task automatic push_pool_load(input int k, input logic [3:0] slot);
    int         r;
    logic [7:0] len;
    logic       en;
    r  = $urandom_range(0, 9);
    en = $urandom_range(0, 6) != 0;
    if (r < 8) len = pool_len[k];
    else if (r == 8) len = 8'(pool_v6[k] ? $urandom_range(129, 255) : $urandom_range(33, 255));
    else len = 8'($urandom_range(0, 255));
    push_item(make_load(slot, pool_v6[k], split_addr(pool_v6[k], pool_net[k]), len, en));
    stim_count++;
  endtask

  // A peer followed by a hop list, sometimes without its last-entry flag
  task automatic push_request();
    logic         v6;
    logic [127:0] hl;
    int           hops;
    pick_addr(v6, hl);
    push_item(make_peer(v6, hl, $urandom_range(0, 9) != 0));
    hops = $urandom_range(1, 5);
    for (int h = 0; h < hops; h++) begin
      pick_addr(v6, hl);
      push_item(make_hop(v6, hl, $urandom_range(0, 6) == 0,
                         (h == hops - 1) && ($urandom_range(0, 19) != 0)));
    end
    stim_count += hops + 1;
  endtask

  task automatic push_noise();
    tpris_in_t it;
    logic      v6;
    logic [127:0] hl;
    case ($urandom_range(0, 2))
      0: begin
        pick_addr(v6, hl);
        push_item(make_hop(v6, hl, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
      end
      1: begin
        it     = noise_item();
        it.cmd = CmdSpare;
        push_item(it);
      end
      default: push_item(noise_item());
    endcase
  endtask

  task automatic fill_directed();
    logic [127:0] ones;
    logic [127:0] doc_net;
    ones    = ~128'd0;
    doc_net = {64'h2001_0db8_0000_0000, 64'd0};
    push_item(make_peer(1'b0, v4(32'hC0A8_0001), 1'b0));
    push_item(make_load(4'd0, 1'b0, v4(32'h0A00_0000), 8'd8, 1'b1));
    push_item(make_load(4'd1, 1'b0, v4(32'h0A00_0000), 8'd33, 1'b1));
    push_item(make_load(4'd2, 1'b1, doc_net, 8'd129, 1'b1));
    push_item(make_load(4'd2, 1'b1, doc_net, 8'd32, 1'b1));
    push_item(make_load(4'd3, 1'b1, ones, 8'd128, 1'b1));
    push_item(make_load(4'd4, 1'b0, v4(32'h0), 8'd255, 1'b0));
    push_item(make_hop(1'b0, v4(32'h0102_0304), 1'b0, 1'b1));
    begin
      tpris_in_t spare;
      spare     = noise_item();
      spare.cmd = CmdSpare;
      push_item(spare);
    end
    // multi-hop walk: skip unspecified and trusted hops
    push_item(make_peer(1'b0, v4(32'h0A01_0203), 1'b1));
    push_item(make_hop(1'b0, {128{1'b1}}, 1'b1, 1'b0));
    push_item(make_hop(1'b0, v4(32'h0AFF_FFFF), 1'b0, 1'b0));
    push_item(make_hop(1'b1, doc_net | 128'd5, 1'b0, 1'b0));
    push_item(make_hop(1'b1, {64'h0A00_0000_0000_0000, 64'd0}, 1'b0, 1'b0));
    // all-trusted walk ends on the peer; a load lands mid-request
    push_item(make_peer(1'b1, ones, 1'b1));
    push_item(make_load(4'd5, 1'b0, v4(32'hC0A8_0000), 8'd16, 1'b1));
    push_item(make_hop(1'b0, v4(32'hC0A8_0101), 1'b0, 1'b1));
    // a new peer restarts an open request
    push_item(make_peer(1'b0, v4(32'h0A00_0001), 1'b1));
    push_item(make_peer(1'b0, v4(32'h0000_0000), 1'b1));
    // zero prefix trusts the whole family
    push_item(make_load(4'd6, 1'b0, v4(32'h0), 8'd0, 1'b1));
    push_item(make_peer(1'b0, v4(32'hFFFF_FFFF), 1'b1));
    push_item(make_hop(1'b0, v4(32'h0102_0304), 1'b0, 1'b1));
    push_item(make_load(4'd6, 1'b0, v4(32'h0), 8'd0, 1'b0));
    // single-address mode
    push_mode(1'b0);
    push_item(make_peer(1'b0, v4(32'h0A00_0002), 1'b1));
    push_item(make_hop(1'b0, v4(32'h0A00_0003), 1'b1, 1'b0));
    push_item(make_peer(1'b0, v4(32'h0A00_0002), 1'b1));
    push_item(make_hop(1'b0, v4(32'h0A00_0009), 1'b0, 1'b0));
  endtask

  initial begin : stimulus
    int target;
    int r;
    fill_directed();
    seed_pool();
    for (int p = 0; p < 6; p++) begin
      push_mode(p[0]);
      if (p == 0) begin
        for (int k = 0; k < PoolSize; k++) begin
          push_item(make_load(4'(k), pool_v6[k], split_addr(pool_v6[k], pool_net[k]),
                              pool_len[k], 1'b1));
        end
      end
      target = stim_count + PhaseItems;
      while (stim_count < target) begin
        r = $urandom_range(0, 99);
        if (r < 12) push_pool_load($urandom_range(0, PoolSize - 1), 4'($urandom_range(0, 15)));
        else if (r < 17) push_noise();
        else push_request();
      end
    end

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending.size() != 0 || in_accepted != in_issued || cfg_accepted != cfg_issued ||
           expected_picks.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (TailCycles) @(negedge clk_i);
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
